[rtl/abps_pkg.sv]
// shared types, codes and pattern rom for the alarm buzzer pattern sequencer
package abps_pkg;

  localparam int ElapsedW = 16;
  localparam int StepTimeW = 10;
  localparam int StepPosW = 3;
  localparam int MelodyTimeW = 10;
  localparam int MelodyPosW = 3;
  localparam int FbTimeW = 9;
  localparam int FbPosW = 2;
  localparam logic [7:0] MaxHour = 8'd23;
  localparam logic [7:0] MaxMinute = 8'd59;

  typedef enum logic [2:0] {
    ACT_TICK     = 3'd0,
    ACT_RTC      = 3'd1,
    ACT_DISMISS  = 3'd2,
    ACT_SOFT     = 3'd3,
    ACT_FEEDBACK = 3'd4,
    ACT_SET      = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    PAT_LOUD   = 2'd0,
    PAT_SOFT   = 2'd1,
    PAT_FB_EN  = 2'd2,
    PAT_FB_DIS = 2'd3
  } pattern_t;

  typedef struct packed {
    logic [StepTimeW-1:0] dur;
    logic                 on;
  } pat_entry_t;

  // result of one pattern step from the shared step unit
  typedef struct packed {
    logic [StepPosW-1:0]  pos_norm;
    logic                 on;
    logic                 ends;
    logic                 wrap;
    logic [StepPosW-1:0]  pos_next;
    logic [StepTimeW-1:0] t_sum;
    logic [ElapsedW-1:0]  elapsed_left;
  } step_res_t;

  function automatic logic [StepPosW-1:0] pattern_len(input pattern_t pat);
    logic [StepPosW-1:0] len;
    unique case (pat)
      PAT_LOUD:   len = 3'd6;
      PAT_SOFT:   len = 3'd4;
      PAT_FB_EN:  len = 3'd3;
      PAT_FB_DIS: len = 3'd1;
      default:    len = 3'd1;
    endcase
    return len;
  endfunction

  function automatic pat_entry_t pattern_step(input pattern_t pat,
                                              input logic [StepPosW-1:0] pos);
    pat_entry_t e;
    e = '{dur: 10'd0, on: 1'b0};
    unique case (pat)
      PAT_LOUD: begin
        unique case (pos)
          3'd0:    e = '{dur: 10'd120, on: 1'b1};
          3'd1:    e = '{dur: 10'd80,  on: 1'b0};
          3'd2:    e = '{dur: 10'd120, on: 1'b1};
          3'd3:    e = '{dur: 10'd80,  on: 1'b0};
          3'd4:    e = '{dur: 10'd320, on: 1'b1};
          3'd5:    e = '{dur: 10'd700, on: 1'b0};
          default: e = '{dur: 10'd120, on: 1'b1};
        endcase
      end
      PAT_SOFT: begin
        unique case (pos)
          3'd0:    e = '{dur: 10'd70,  on: 1'b1};
          3'd1:    e = '{dur: 10'd430, on: 1'b0};
          3'd2:    e = '{dur: 10'd70,  on: 1'b1};
          3'd3:    e = '{dur: 10'd950, on: 1'b0};
          default: e = '{dur: 10'd70,  on: 1'b1};
        endcase
      end
      PAT_FB_EN: begin
        unique case (pos)
          3'd0:    e = '{dur: 10'd90, on: 1'b1};
          3'd1:    e = '{dur: 10'd70, on: 1'b0};
          3'd2:    e = '{dur: 10'd90, on: 1'b1};
          default: e = '{dur: 10'd90, on: 1'b1};
        endcase
      end
      PAT_FB_DIS: e = '{dur: 10'd260, on: 1'b1};
      default:    e = '{dur: 10'd260, on: 1'b1};
    endcase
    return e;
  endfunction

endpackage

[rtl/abps_step_unit.sv]
// shared step unit: looks up one pattern step and works out its remaining time
module abps_step_unit import abps_pkg::*; (
  input  pattern_t              pat,
  input  logic [StepPosW-1:0]   pos,
  input  logic [StepTimeW-1:0]  t,
  input  logic [ElapsedW-1:0]   elapsed,
  output step_res_t             res
);

  logic [StepPosW-1:0]  len;
  logic [StepPosW-1:0]  pos_norm;
  logic [StepPosW-1:0]  pos_inc;
  pat_entry_t           entry;
  logic [StepTimeW-1:0] remaining;

  always_comb begin
    len       = pattern_len(pat);
    // a position past the pattern end restarts at the first step
    pos_norm  = (pos >= len) ? '0 : pos;
    entry     = pattern_step(pat, pos_norm);
    remaining = (t < entry.dur) ? (entry.dur - t) : '0;
    pos_inc   = pos_norm + 3'd1;

    res.pos_norm     = pos_norm;
    res.on           = entry.on;
    res.ends         = (elapsed >= {{(ElapsedW-StepTimeW){1'b0}}, remaining});
    res.wrap         = (pos_inc >= len);
    res.pos_next     = res.wrap ? '0 : pos_inc;
    res.t_sum        = t + elapsed[StepTimeW-1:0];
    res.elapsed_left = elapsed - {{(ElapsedW-StepTimeW){1'b0}}, remaining};
  end

endmodule

[rtl/alarm_buzzer_pattern_sequencer.sv]
// top level of the alarm buzzer pattern sequencer: action decode, state and step walk
// An action that does not walk a pattern finishes in the cycle it is accepted, so its result
// beat is registered and follows in the next cycle. This covers every action other than tick,
// and a tick while not ringing with no feedback tone running. A tick that walks a pattern goes
// one step per cycle through the shared step unit, stepping on past each step boundary that it
// crosses, so the walk grows longer with tick_ms. in_ready is low while a walk runs and while
// an untaken result beat fills the output register.
module alarm_buzzer_pattern_sequencer import abps_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          action,
  input  logic                flag,
  input  logic [ElapsedW-1:0] tick_ms,
  input  logic [7:0]          alarm_hour,
  input  logic [7:0]          alarm_minute,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                buzzer_on,
  output logic                level_changed,
  output logic                is_ringing,
  output logic                status,
  output logic                clear_rtc_flag
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t state, state_next;

  logic ringing, ringing_next;
  logic soft_mode, soft_mode_next;
  logic alarm_armed, alarm_armed_next;
  logic buzzer_level, buzzer_level_next;
  logic [MelodyPosW-1:0]  melody_position, melody_position_next;
  logic [MelodyTimeW-1:0] melody_time, melody_time_next;
  logic feedback_running, feedback_running_next;
  logic feedback_enable_tone, feedback_enable_tone_next;
  logic [FbPosW-1:0]  feedback_position, feedback_position_next;
  logic [FbTimeW-1:0] feedback_time, feedback_time_next;

  // walk working registers
  pattern_t             wpat, wpat_next;
  logic [StepPosW-1:0]  wpos, wpos_next;
  logic [StepTimeW-1:0] wtime, wtime_next;
  logic [ElapsedW-1:0]  welapsed, welapsed_next;
  logic                 wchanged, wchanged_next;

  step_res_t step;

  logic out_load;
  logic o_changed, o_status, o_clear;
  logic accept;
  logic ch;
  logic wb;
  logic [StepPosW-1:0]  wb_pos;
  logic [StepTimeW-1:0] wb_time;

  abps_step_unit u_step (
    .pat     (wpat),
    .pos     (wpos),
    .t       (wtime),
    .elapsed (welapsed),
    .res     (step)
  );

  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next                = state;
    ringing_next              = ringing;
    soft_mode_next            = soft_mode;
    alarm_armed_next          = alarm_armed;
    buzzer_level_next         = buzzer_level;
    melody_position_next      = melody_position;
    melody_time_next          = melody_time;
    feedback_running_next     = feedback_running;
    feedback_enable_tone_next = feedback_enable_tone;
    feedback_position_next    = feedback_position;
    feedback_time_next        = feedback_time;
    wpat_next                 = wpat;
    wpos_next                 = wpos;
    wtime_next                = wtime;
    welapsed_next             = welapsed;
    wchanged_next             = wchanged;
    out_load                  = 1'b0;
    o_changed                 = 1'b0;
    o_status                  = 1'b0;
    o_clear                   = 1'b0;
    ch                        = 1'b0;
    wb                        = 1'b0;
    wb_pos                    = step.pos_norm;
    wb_time                   = wtime;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          out_load = 1'b1;
          unique case (action)
            ACT_TICK: begin
              if (!ringing) begin
                melody_position_next = '0;
                melody_time_next     = '0;
                if (feedback_running) begin
                  out_load      = 1'b0;
                  wpat_next     = feedback_enable_tone ? PAT_FB_EN : PAT_FB_DIS;
                  wpos_next     = {{(StepPosW-FbPosW){1'b0}}, feedback_position};
                  wtime_next    = {{(StepTimeW-FbTimeW){1'b0}}, feedback_time};
                  welapsed_next = tick_ms;
                  wchanged_next = 1'b0;
                  state_next    = ST_WALK;
                end else begin
                  o_changed         = buzzer_level;
                  buzzer_level_next = 1'b0;
                end
              end else begin
                feedback_running_next     = 1'b0;
                feedback_enable_tone_next = 1'b0;
                feedback_position_next    = '0;
                feedback_time_next        = '0;
                out_load      = 1'b0;
                wpat_next     = soft_mode ? PAT_SOFT : PAT_LOUD;
                wpos_next     = melody_position;
                wtime_next    = melody_time;
                welapsed_next = tick_ms;
                wchanged_next = 1'b0;
                state_next    = ST_WALK;
              end
            end
            ACT_RTC: begin
              if (flag && alarm_armed) begin
                ringing_next              = 1'b1;
                soft_mode_next            = 1'b0;
                melody_position_next      = '0;
                melody_time_next          = '0;
                feedback_running_next     = 1'b0;
                feedback_enable_tone_next = 1'b0;
                feedback_position_next    = '0;
                feedback_time_next        = '0;
                buzzer_level_next         = 1'b1;
              end else if (flag) begin
                o_clear = 1'b1;
              end
            end
            ACT_DISMISS: begin
              ringing_next              = 1'b0;
              soft_mode_next            = 1'b0;
              melody_position_next      = '0;
              melody_time_next          = '0;
              feedback_running_next     = 1'b0;
              feedback_enable_tone_next = 1'b0;
              feedback_position_next    = '0;
              feedback_time_next        = '0;
              buzzer_level_next         = 1'b0;
              o_clear                   = 1'b1;
            end
            ACT_SOFT: begin
              if (soft_mode != flag) begin
                soft_mode_next       = flag;
                melody_position_next = '0;
                melody_time_next     = '0;
              end
            end
            ACT_FEEDBACK: begin
              if (!ringing) begin
                feedback_running_next     = 1'b1;
                feedback_enable_tone_next = flag;
                feedback_position_next    = '0;
                feedback_time_next        = '0;
              end
            end
            ACT_SET: begin
              if (alarm_hour <= MaxHour && alarm_minute <= MaxMinute) begin
                alarm_armed_next          = flag;
                ringing_next              = 1'b0;
                soft_mode_next            = 1'b0;
                melody_position_next      = '0;
                melody_time_next          = '0;
                feedback_running_next     = 1'b0;
                feedback_enable_tone_next = 1'b0;
                feedback_position_next    = '0;
                feedback_time_next        = '0;
                buzzer_level_next         = 1'b0;
                o_clear                   = 1'b1;
              end else begin
                o_status = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        ch = wchanged;
        if (welapsed == '0) begin
          wb       = 1'b1;
          out_load = 1'b1;
        end else begin
          ch                = wchanged | (buzzer_level != step.on);
          buzzer_level_next = step.on;
          if (!step.ends) begin
            wb       = 1'b1;
            wb_time  = step.t_sum;
            out_load = 1'b1;
          end else if (step.wrap && (wpat == PAT_FB_EN || wpat == PAT_FB_DIS)) begin
            // one-shot tone ran past its last step: silence and stop
            ch                        = ch | step.on;
            buzzer_level_next         = 1'b0;
            feedback_running_next     = 1'b0;
            feedback_enable_tone_next = 1'b0;
            feedback_position_next    = '0;
            feedback_time_next        = '0;
            out_load                  = 1'b1;
          end else begin
            wpos_next     = step.pos_next;
            wtime_next    = '0;
            welapsed_next = step.elapsed_left;
            wchanged_next = ch;
          end
        end
        if (wb) begin
          if (wpat == PAT_LOUD || wpat == PAT_SOFT) begin
            melody_position_next = wb_pos;
            melody_time_next     = wb_time;
          end else begin
            feedback_position_next = wb_pos[FbPosW-1:0];
            feedback_time_next     = wb_time[FbTimeW-1:0];
          end
        end
        if (out_load) begin
          o_changed  = ch;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= ST_IDLE;
      ringing              <= 1'b0;
      soft_mode            <= 1'b0;
      alarm_armed          <= 1'b0;
      buzzer_level         <= 1'b0;
      melody_position      <= '0;
      melody_time          <= '0;
      feedback_running     <= 1'b0;
      feedback_enable_tone <= 1'b0;
      feedback_position    <= '0;
      feedback_time        <= '0;
      out_valid            <= 1'b0;
    end else begin
      state                <= state_next;
      ringing              <= ringing_next;
      soft_mode            <= soft_mode_next;
      alarm_armed          <= alarm_armed_next;
      buzzer_level         <= buzzer_level_next;
      melody_position      <= melody_position_next;
      melody_time          <= melody_time_next;
      feedback_running     <= feedback_running_next;
      feedback_enable_tone <= feedback_enable_tone_next;
      feedback_position    <= feedback_position_next;
      feedback_time        <= feedback_time_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wpat     <= wpat_next;
    wpos     <= wpos_next;
    wtime    <= wtime_next;
    welapsed <= welapsed_next;
    wchanged <= wchanged_next;
    if (out_load) begin
      buzzer_on      <= buzzer_level_next;
      level_changed  <= o_changed;
      is_ringing     <= ringing_next;
      status         <= o_status;
      clear_rtc_flag <= o_clear;
    end
  end

endmodule
